### design/dpb_pkg.sv
// ----------------------------------------------------------------------------
// dpb_pkg: shared types and constants for the depth pixel backprojection
// Register indexes, the configuration bundle, field widths and reset values.
// ----------------------------------------------------------------------------
package dpb_pkg;

  localparam int COORD_BITS_DEFAULT = 12;
  localparam int QUEUE_DEPTH        = 4;

  localparam int CFG_INDEX_BITS = 3;
  localparam int CFG_DATA_BITS  = 32;

  localparam int SIZE_BITS      = 12;
  localparam int CENTER_BITS    = 13;
  localparam int INV_FOCAL_BITS = 24;
  localparam int INV_SCALE_BITS = 32;
  localparam int DEPTH_BITS     = 16;
  localparam int COLOR_BITS     = 8;
  localparam int POINT_BITS     = 32;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_IMAGE_WIDTH     = 3'd0,
    REG_IMAGE_HEIGHT    = 3'd1,
    REG_CENTER_X_HALF   = 3'd2,
    REG_CENTER_Y_HALF   = 3'd3,
    REG_INV_FOCAL_X     = 3'd4,
    REG_INV_FOCAL_Y     = 3'd5,
    REG_INV_DEPTH_SCALE = 3'd6
  } cfg_reg_t;

  typedef struct packed {
    logic [SIZE_BITS-1:0]      image_width;
    logic [SIZE_BITS-1:0]      image_height;
    logic [CENTER_BITS-1:0]    center_x_half;
    logic [CENTER_BITS-1:0]    center_y_half;
    logic [INV_FOCAL_BITS-1:0] inv_focal_x;
    logic [INV_FOCAL_BITS-1:0] inv_focal_y;
    logic [INV_SCALE_BITS-1:0] inv_depth_scale;
  } cfg_t;

  localparam logic [SIZE_BITS-1:0]      RESET_IMAGE_WIDTH     = 12'd640;
  localparam logic [SIZE_BITS-1:0]      RESET_IMAGE_HEIGHT    = 12'd480;
  localparam logic [CENTER_BITS-1:0]    RESET_CENTER_X_HALF   = 13'd651;
  localparam logic [CENTER_BITS-1:0]    RESET_CENTER_Y_HALF   = 13'd507;
  localparam logic [INV_FOCAL_BITS-1:0] RESET_INV_FOCAL_X     = 24'd32389;
  localparam logic [INV_FOCAL_BITS-1:0] RESET_INV_FOCAL_Y     = 24'd32326;
  localparam logic [INV_SCALE_BITS-1:0] RESET_INV_DEPTH_SCALE = 32'd4294967;

endpackage

### design/dpb_front.sv
// ----------------------------------------------------------------------------
// dpb_front: pixel position tracking and classification
// Counts columns and rows of the raster and forwards only pixels with a depth.
// ----------------------------------------------------------------------------
module dpb_front #(
  parameter int COORD_BITS = dpb_pkg::COORD_BITS_DEFAULT
) (
  input  logic                              clk,
  input  logic                              rst,
  input  dpb_pkg::cfg_t                     cfg,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [dpb_pkg::DEPTH_BITS-1:0]    depth_raw,
  output logic                              q_valid,
  input  logic                              q_ready,
  output logic [COORD_BITS-1:0]             q_column,
  output logic [COORD_BITS-1:0]             q_row
);

  localparam int CMP_BITS = (COORD_BITS > dpb_pkg::SIZE_BITS) ? COORD_BITS
                                                              : dpb_pkg::SIZE_BITS;

  logic [COORD_BITS-1:0] column_count;
  logic [COORD_BITS-1:0] row_count;
  logic [COORD_BITS-1:0] column_inc;
  logic [COORD_BITS-1:0] row_inc;
  logic                  accept;

  // Every beat waits on queue space, so the counters never run ahead of it.
  assign in_ready   = q_ready;
  assign accept     = in_valid && q_ready;
  assign q_valid    = in_valid && (depth_raw != '0);
  assign q_column   = column_count;
  assign q_row      = row_count;
  assign column_inc = column_count + COORD_BITS'(1);
  assign row_inc    = row_count + COORD_BITS'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
    end else if (accept) begin
      if (CMP_BITS'(column_inc) >= CMP_BITS'(cfg.image_width)) begin
        column_count <= '0;
        if (CMP_BITS'(row_inc) >= CMP_BITS'(cfg.image_height)) begin
          row_count <= '0;
        end else begin
          row_count <= row_inc;
        end
      end else begin
        column_count <= column_inc;
      end
    end
  end

endmodule

### design/dpb_queue.sv
// ----------------------------------------------------------------------------
// dpb_queue: short first-in first-out buffer between front and back
// Holds classified pixels so that either side can stall on its own.
// ----------------------------------------------------------------------------
module dpb_queue #(
  parameter int DATA_BITS = 64,
  parameter int DEPTH     = dpb_pkg::QUEUE_DEPTH
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push_valid,
  output logic                 push_ready,
  input  logic [DATA_BITS-1:0] push_data,
  output logic                 pop_valid,
  input  logic                 pop_ready,
  output logic [DATA_BITS-1:0] pop_data
);

  localparam int ADDR_BITS  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int COUNT_BITS = $clog2(DEPTH + 1);

  logic [DATA_BITS-1:0]  mem [DEPTH];
  logic [ADDR_BITS-1:0]  wr_ptr;
  logic [ADDR_BITS-1:0]  rd_ptr;
  logic [COUNT_BITS-1:0] count;
  logic                  do_push;
  logic                  do_pop;

  assign push_ready = (count != COUNT_BITS'(DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_data   = mem[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == ADDR_BITS'(DEPTH - 1)) ? '0 : wr_ptr + ADDR_BITS'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == ADDR_BITS'(DEPTH - 1)) ? '0 : rd_ptr + ADDR_BITS'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + COUNT_BITS'(1);
      end else if (do_pop && !do_push) begin
        count <= count - COUNT_BITS'(1);
      end
    end
  end

endmodule

### design/dpb_back.sv
// ----------------------------------------------------------------------------
// dpb_back: fixed-point backprojection pipeline
// Five stages: depth scaling and offsets, focal products, split depth
// products, rounding sum, and sign with saturation into the output register.
// ----------------------------------------------------------------------------
module dpb_back #(
  parameter int COORD_BITS = dpb_pkg::COORD_BITS_DEFAULT
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  dpb_pkg::cfg_t                         cfg,
  input  logic                                  q_valid,
  output logic                                  q_ready,
  input  logic [dpb_pkg::DEPTH_BITS-1:0]        q_depth,
  input  logic [COORD_BITS-1:0]                 q_column,
  input  logic [COORD_BITS-1:0]                 q_row,
  input  logic [3*dpb_pkg::COLOR_BITS-1:0]      q_color,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic [dpb_pkg::POINT_BITS-1:0]        x_bits,
  output logic [dpb_pkg::POINT_BITS-1:0]        y_bits,
  output logic [dpb_pkg::POINT_BITS-1:0]        z_bits,
  output logic [3*dpb_pkg::COLOR_BITS-1:0]      out_color
);

  localparam int PB        = dpb_pkg::POINT_BITS;
  localparam int CB        = 3 * dpb_pkg::COLOR_BITS;
  localparam int HALF_BITS = PB / 2;
  localparam int ZP_BITS   = dpb_pkg::DEPTH_BITS + dpb_pkg::INV_SCALE_BITS;
  localparam int WIDE_POS  = (COORD_BITS + 1 > dpb_pkg::CENTER_BITS) ? COORD_BITS + 1
                                                                     : dpb_pkg::CENTER_BITS;
  localparam int OFF_BITS  = WIDE_POS + 1;
  localparam int MAG_BITS  = OFF_BITS - 1;
  localparam int A_BITS    = MAG_BITS + dpb_pkg::INV_FOCAL_BITS;
  localparam int P_BITS    = A_BITS + HALF_BITS;
  localparam int SUM_BITS  = P_BITS + HALF_BITS + 1;
  localparam int RND_SHIFT = 25;
  localparam int R_BITS    = SUM_BITS - RND_SHIFT;

  localparam logic [ZP_BITS-1:0]  Z_ROUND   = ZP_BITS'(1) << (HALF_BITS - 1);
  localparam logic [SUM_BITS-1:0] SUM_ROUND = SUM_BITS'(1) << (RND_SHIFT - 1);
  localparam logic [PB-1:0]       POS_MAX   = {1'b0, {(PB-1){1'b1}}};
  localparam logic [PB-1:0]       NEG_MAX   = {1'b1, {(PB-1){1'b0}}};

  function automatic logic [PB-1:0] sign_sat(input logic [R_BITS-1:0] r, input logic neg);
    logic over;
    logic [PB-1:0] low;
    over = |r[R_BITS-1:PB-1];
    low  = r[PB-1:0];
    if (neg) begin
      sign_sat = over ? NEG_MAX : (~low + PB'(1));
    end else begin
      sign_sat = over ? POS_MAX : low;
    end
  endfunction

  logic advance;
  logic v1, v2, v3, v4;

  // Stage 1 logic.
  logic signed [OFF_BITS-1:0] off_x, off_y;
  logic [OFF_BITS-1:0]        abs_x, abs_y;
  logic [ZP_BITS-1:0]         z_prod;

  logic [PB-1:0]       z1, z2, z3, z4;
  logic [MAG_BITS-1:0] mag_x1, mag_y1;
  logic                neg_x1, neg_y1, neg_x2, neg_y2, neg_x3, neg_y3, neg_x4, neg_y4;
  logic [CB-1:0]       c1, c2, c3, c4;
  logic [A_BITS-1:0]   a_x2, a_y2;
  logic [P_BITS-1:0]   hi_x3, lo_x3, hi_y3, lo_y3;
  logic [SUM_BITS-1:0] sum_x, sum_y;
  logic [R_BITS-1:0]   r_x4, r_y4;

  // The whole pipeline moves together unless a result waits at the output.
  assign advance = !out_valid || out_ready;
  assign q_ready = advance;

  assign off_x  = $signed(OFF_BITS'({q_column, 1'b0})) - $signed(OFF_BITS'(cfg.center_x_half));
  assign off_y  = $signed(OFF_BITS'({q_row, 1'b0})) - $signed(OFF_BITS'(cfg.center_y_half));
  assign abs_x  = off_x[OFF_BITS-1] ? OFF_BITS'(-off_x) : OFF_BITS'(off_x);
  assign abs_y  = off_y[OFF_BITS-1] ? OFF_BITS'(-off_y) : OFF_BITS'(off_y);
  assign z_prod = ZP_BITS'(q_depth) * ZP_BITS'(cfg.inv_depth_scale) + Z_ROUND;

  // Exact a * z, with z split in halves: (hi << 16) + lo, rounded at bit 25.
  assign sum_x = {hi_x3, {HALF_BITS{1'b0}}} + SUM_BITS'(lo_x3) + SUM_ROUND;
  assign sum_y = {hi_y3, {HALF_BITS{1'b0}}} + SUM_BITS'(lo_y3) + SUM_ROUND;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      v4        <= 1'b0;
      out_valid <= 1'b0;
    end else if (advance) begin
      v1        <= q_valid;
      v2        <= v1;
      v3        <= v2;
      v4        <= v3;
      out_valid <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      z1     <= z_prod[ZP_BITS-1:HALF_BITS];
      mag_x1 <= abs_x[MAG_BITS-1:0];
      mag_y1 <= abs_y[MAG_BITS-1:0];
      neg_x1 <= off_x[OFF_BITS-1];
      neg_y1 <= off_y[OFF_BITS-1];
      c1     <= q_color;

      a_x2   <= A_BITS'(mag_x1) * A_BITS'(cfg.inv_focal_x);
      a_y2   <= A_BITS'(mag_y1) * A_BITS'(cfg.inv_focal_y);
      z2     <= z1;
      neg_x2 <= neg_x1;
      neg_y2 <= neg_y1;
      c2     <= c1;

      hi_x3  <= P_BITS'(a_x2) * P_BITS'(z2[PB-1:HALF_BITS]);
      lo_x3  <= P_BITS'(a_x2) * P_BITS'(z2[HALF_BITS-1:0]);
      hi_y3  <= P_BITS'(a_y2) * P_BITS'(z2[PB-1:HALF_BITS]);
      lo_y3  <= P_BITS'(a_y2) * P_BITS'(z2[HALF_BITS-1:0]);
      z3     <= z2;
      neg_x3 <= neg_x2;
      neg_y3 <= neg_y2;
      c3     <= c2;

      r_x4   <= sum_x[SUM_BITS-1:RND_SHIFT];
      r_y4   <= sum_y[SUM_BITS-1:RND_SHIFT];
      z4     <= z3;
      neg_x4 <= neg_x3;
      neg_y4 <= neg_y3;
      c4     <= c3;

      x_bits    <= sign_sat(r_x4, neg_x4);
      y_bits    <= sign_sat(r_y4, neg_y4);
      z_bits    <= z4;
      out_color <= c4;
    end
  end

endmodule

### design/depth_pixel_backprojection.sv
// ----------------------------------------------------------------------------
// depth_pixel_backprojection: pinhole depth pixel to colored 3D point
// Holds the configuration registers and joins front, queue and back.
//
//   channel   direction  handshake            payload
//   in        input      in_valid/in_ready    depth_raw, blue, green, red
//   out       output     out_valid/out_ready  point_x, point_y, point_z,
//                                             out_blue, out_green, out_red
//   cfg       input      cfg_write            cfg_index, cfg_data
//
// One pixel beat is accepted per cycle while the queue has room; each
// pixel is written into the queue, then passes the five-stage back pipeline.
// Reset loads the default camera registers, zeroes the position counters and
// empties the queue; no other pass follows, so input is taken right away.
// A stalled output freezes the back pipeline; the four-entry queue then
// fills, and in_ready drops once it is full. Zero-depth pixels yield no beat.
// ----------------------------------------------------------------------------
module depth_pixel_backprojection #(
  parameter int COORD_BITS = dpb_pkg::COORD_BITS_DEFAULT
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_write,
  input  logic [dpb_pkg::CFG_INDEX_BITS-1:0]    cfg_index,
  input  logic [dpb_pkg::CFG_DATA_BITS-1:0]     cfg_data,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic [dpb_pkg::DEPTH_BITS-1:0]        depth_raw,
  input  logic [dpb_pkg::COLOR_BITS-1:0]        blue,
  input  logic [dpb_pkg::COLOR_BITS-1:0]        green,
  input  logic [dpb_pkg::COLOR_BITS-1:0]        red,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic signed [dpb_pkg::POINT_BITS-1:0] point_x,
  output logic signed [dpb_pkg::POINT_BITS-1:0] point_y,
  output logic [dpb_pkg::POINT_BITS-1:0]        point_z,
  output logic [dpb_pkg::COLOR_BITS-1:0]        out_blue,
  output logic [dpb_pkg::COLOR_BITS-1:0]        out_green,
  output logic [dpb_pkg::COLOR_BITS-1:0]        out_red
);

  localparam int COLB      = dpb_pkg::COLOR_BITS;
  localparam int DATA_BITS = dpb_pkg::DEPTH_BITS + 2 * COORD_BITS + 3 * COLB;

  dpb_pkg::cfg_t cfg;

  logic                           front_valid;
  logic                           front_ready;
  logic [COORD_BITS-1:0]          front_column;
  logic [COORD_BITS-1:0]          front_row;
  logic [DATA_BITS-1:0]           push_data;
  logic                           pop_valid;
  logic                           pop_ready;
  logic [DATA_BITS-1:0]           pop_data;
  logic [dpb_pkg::DEPTH_BITS-1:0] pop_depth;
  logic [COORD_BITS-1:0]          pop_column;
  logic [COORD_BITS-1:0]          pop_row;
  logic [3*COLB-1:0]              pop_color;
  logic [3*COLB-1:0]              out_color;
  logic [dpb_pkg::POINT_BITS-1:0] x_bits;
  logic [dpb_pkg::POINT_BITS-1:0] y_bits;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.image_width     <= dpb_pkg::RESET_IMAGE_WIDTH;
      cfg.image_height    <= dpb_pkg::RESET_IMAGE_HEIGHT;
      cfg.center_x_half   <= dpb_pkg::RESET_CENTER_X_HALF;
      cfg.center_y_half   <= dpb_pkg::RESET_CENTER_Y_HALF;
      cfg.inv_focal_x     <= dpb_pkg::RESET_INV_FOCAL_X;
      cfg.inv_focal_y     <= dpb_pkg::RESET_INV_FOCAL_Y;
      cfg.inv_depth_scale <= dpb_pkg::RESET_INV_DEPTH_SCALE;
    end else if (cfg_write) begin
      unique case (cfg_index)
        dpb_pkg::REG_IMAGE_WIDTH:
          cfg.image_width     <= cfg_data[dpb_pkg::SIZE_BITS-1:0];
        dpb_pkg::REG_IMAGE_HEIGHT:
          cfg.image_height    <= cfg_data[dpb_pkg::SIZE_BITS-1:0];
        dpb_pkg::REG_CENTER_X_HALF:
          cfg.center_x_half   <= cfg_data[dpb_pkg::CENTER_BITS-1:0];
        dpb_pkg::REG_CENTER_Y_HALF:
          cfg.center_y_half   <= cfg_data[dpb_pkg::CENTER_BITS-1:0];
        dpb_pkg::REG_INV_FOCAL_X:
          cfg.inv_focal_x     <= cfg_data[dpb_pkg::INV_FOCAL_BITS-1:0];
        dpb_pkg::REG_INV_FOCAL_Y:
          cfg.inv_focal_y     <= cfg_data[dpb_pkg::INV_FOCAL_BITS-1:0];
        dpb_pkg::REG_INV_DEPTH_SCALE:
          cfg.inv_depth_scale <= cfg_data[dpb_pkg::INV_SCALE_BITS-1:0];
        default: begin
        end
      endcase
    end
  end

  dpb_front #(
    .COORD_BITS (COORD_BITS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .depth_raw (depth_raw),
    .q_valid   (front_valid),
    .q_ready   (front_ready),
    .q_column  (front_column),
    .q_row     (front_row)
  );

  assign push_data = {depth_raw, front_column, front_row, blue, green, red};

  dpb_queue #(
    .DATA_BITS (DATA_BITS),
    .DEPTH     (dpb_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (front_valid),
    .push_ready (front_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  assign {pop_depth, pop_column, pop_row, pop_color} = pop_data;

  dpb_back #(
    .COORD_BITS (COORD_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .q_valid   (pop_valid),
    .q_ready   (pop_ready),
    .q_depth   (pop_depth),
    .q_column  (pop_column),
    .q_row     (pop_row),
    .q_color   (pop_color),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .x_bits    (x_bits),
    .y_bits    (y_bits),
    .z_bits    (point_z),
    .out_color (out_color)
  );

  assign point_x = $signed(x_bits);
  assign point_y = $signed(y_bits);
  assign {out_blue, out_green, out_red} = out_color;

endmodule

### test/depth_pixel_backprojection_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// depth_pixel_backprojection_tb: self-checking regression for the point block
// A directed table covers reset values, saturation, zero depth, counter wrap,
// degenerate image sizes and register masking. Random frames follow under
// changing camera settings. Every beat is checked against a local predictor,
// and both channels idle and stall at random.
// ----------------------------------------------------------------------------
module depth_pixel_backprojection_tb;

  localparam int COORD_W       = dpb_pkg::COORD_BITS_DEFAULT;
  localparam int SETTLE_CYCLES = 12;
  localparam int DRAIN_CYCLES  = 20;
  localparam int STALL_LIMIT   = 2000;
  localparam int RANDOM_PIXELS = 1950;
  localparam int REPORT_LIMIT  = 10;

  localparam logic [dpb_pkg::CFG_INDEX_BITS-1:0] REG_UNMAPPED = 3'd7;
  localparam logic [dpb_pkg::POINT_BITS-1:0] POINT_MIN = 32'h8000_0000;
  localparam logic [dpb_pkg::POINT_BITS-1:0] POINT_MAX = 32'h7FFF_FFFF;
  // Depth of 65535 at the largest depth scale.
  localparam logic [dpb_pkg::POINT_BITS-1:0] Z_FULL    = 32'hFFFE_FFFF;

  typedef struct packed {
    logic [dpb_pkg::POINT_BITS-1:0] x;
    logic [dpb_pkg::POINT_BITS-1:0] y;
    logic [dpb_pkg::POINT_BITS-1:0] z;
    logic [dpb_pkg::COLOR_BITS-1:0] b;
    logic [dpb_pkg::COLOR_BITS-1:0] g;
    logic [dpb_pkg::COLOR_BITS-1:0] r;
  } cloud_point_t;

  typedef enum logic [1:0] {EXP_PREDICTED, EXP_NONE, EXP_POINT} exp_kind_t;
  typedef enum logic {ROW_PIXEL, ROW_WRITE} row_kind_t;

  typedef struct {
    row_kind_t                          kind;
    logic [dpb_pkg::CFG_INDEX_BITS-1:0] index;
    logic [dpb_pkg::CFG_DATA_BITS-1:0]  data;
    logic [dpb_pkg::DEPTH_BITS-1:0]     depth;
    logic [dpb_pkg::COLOR_BITS-1:0]     b;
    logic [dpb_pkg::COLOR_BITS-1:0]     g;
    logic [dpb_pkg::COLOR_BITS-1:0]     r;
    exp_kind_t                          how;
    logic [dpb_pkg::POINT_BITS-1:0]     x;
    logic [dpb_pkg::POINT_BITS-1:0]     y;
    logic [dpb_pkg::POINT_BITS-1:0]     z;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_write = 1'b0;
  logic [dpb_pkg::CFG_INDEX_BITS-1:0] cfg_index = '0;
  logic [dpb_pkg::CFG_DATA_BITS-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [dpb_pkg::DEPTH_BITS-1:0] depth_raw = '0;
  logic [dpb_pkg::COLOR_BITS-1:0] blue = '0;
  logic [dpb_pkg::COLOR_BITS-1:0] green = '0;
  logic [dpb_pkg::COLOR_BITS-1:0] red = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [dpb_pkg::POINT_BITS-1:0] point_x;
  logic signed [dpb_pkg::POINT_BITS-1:0] point_y;
  logic [dpb_pkg::POINT_BITS-1:0] point_z;
  logic [dpb_pkg::COLOR_BITS-1:0] out_blue;
  logic [dpb_pkg::COLOR_BITS-1:0] out_green;
  logic [dpb_pkg::COLOR_BITS-1:0] out_red;

  // Travels with each pixel beat: how its point is to be expected.
  exp_kind_t beat_check = EXP_PREDICTED;
  logic [dpb_pkg::POINT_BITS-1:0] beat_x = '0;
  logic [dpb_pkg::POINT_BITS-1:0] beat_y = '0;
  logic [dpb_pkg::POINT_BITS-1:0] beat_z = '0;

  // Predictor copy of the camera registers and the pixel position.
  logic [dpb_pkg::SIZE_BITS-1:0] cam_width = dpb_pkg::RESET_IMAGE_WIDTH;
  logic [dpb_pkg::SIZE_BITS-1:0] cam_height = dpb_pkg::RESET_IMAGE_HEIGHT;
  logic [dpb_pkg::CENTER_BITS-1:0] cam_cx_half = dpb_pkg::RESET_CENTER_X_HALF;
  logic [dpb_pkg::CENTER_BITS-1:0] cam_cy_half = dpb_pkg::RESET_CENTER_Y_HALF;
  logic [dpb_pkg::INV_FOCAL_BITS-1:0] cam_inv_fx = dpb_pkg::RESET_INV_FOCAL_X;
  logic [dpb_pkg::INV_FOCAL_BITS-1:0] cam_inv_fy = dpb_pkg::RESET_INV_FOCAL_Y;
  logic [dpb_pkg::INV_SCALE_BITS-1:0] cam_inv_scale = dpb_pkg::RESET_INV_DEPTH_SCALE;
  logic [COORD_W-1:0] col_pos = '0;
  logic [COORD_W-1:0] row_pos = '0;

  cloud_point_t pending_points[$];
  stim_row_t directed_rows[$];
  int mismatches = 0;
  int idle_cycles = 0;
  bit no_gaps = 1'b0;
  int stall_left = 0;
  int mode_left = 0;
  bit sink_steady = 1'b0;

  depth_pixel_backprojection dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .depth_raw (depth_raw),
    .blue      (blue),
    .green     (green),
    .red       (red),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .point_x   (point_x),
    .point_y   (point_y),
    .point_z   (point_z),
    .out_blue  (out_blue),
    .out_green (out_green),
    .out_red   (out_red)
  );

  always #10 clk = ~clk;

  // One axis: half-pixel offset times z times the reciprocal focal length,
  // rounded half away from zero and saturated to signed Q15.16.
  function automatic logic [dpb_pkg::POINT_BITS-1:0] axis_coord(
      input logic [COORD_W-1:0] pos,
      input logic [dpb_pkg::CENTER_BITS-1:0] center_half,
      input logic [dpb_pkg::INV_FOCAL_BITS-1:0] inv_f,
      input logic [dpb_pkg::POINT_BITS-1:0] z);
    logic signed [14:0] offset;
    logic [14:0] mag;
    logic [95:0] prod;
    logic [95:0] scaled;
    offset = $signed({2'b00, pos, 1'b0}) - $signed({2'b00, center_half});
    mag = offset[14] ? -offset : offset;
    prod = 96'(mag) * 96'(inv_f) * 96'(z);
    scaled = (prod + (96'd1 << 24)) >> 25;
    if (offset[14])
      return (scaled >= 96'h8000_0000) ? POINT_MIN : (32'd0 - scaled[31:0]);
    return (scaled > 96'h7FFF_FFFF) ? POINT_MAX : scaled[31:0];
  endfunction

  function automatic cloud_point_t backproject(input logic [dpb_pkg::DEPTH_BITS-1:0] d,
      input logic [dpb_pkg::COLOR_BITS-1:0] b, input logic [dpb_pkg::COLOR_BITS-1:0] g,
      input logic [dpb_pkg::COLOR_BITS-1:0] r);
    logic [47:0] scaled;
    cloud_point_t p;
    scaled = 48'(d) * 48'(cam_inv_scale) + 48'h8000;
    p.z = scaled[47:16];
    p.x = axis_coord(col_pos, cam_cx_half, cam_inv_fx, p.z);
    p.y = axis_coord(row_pos, cam_cy_half, cam_inv_fy, p.z);
    p.b = b;
    p.g = g;
    p.r = r;
    return p;
  endfunction

  function automatic void add_pixel(input logic [dpb_pkg::DEPTH_BITS-1:0] d,
      input logic [dpb_pkg::COLOR_BITS-1:0] b, input logic [dpb_pkg::COLOR_BITS-1:0] g,
      input logic [dpb_pkg::COLOR_BITS-1:0] r, input exp_kind_t how,
      input logic [dpb_pkg::POINT_BITS-1:0] x, input logic [dpb_pkg::POINT_BITS-1:0] y,
      input logic [dpb_pkg::POINT_BITS-1:0] z);
    stim_row_t row;
    row = '{ROW_PIXEL, '0, '0, d, b, g, r, how, x, y, z};
    directed_rows.insert(directed_rows.size(), row);
  endfunction

  function automatic void add_write(input logic [dpb_pkg::CFG_INDEX_BITS-1:0] idx,
      input logic [dpb_pkg::CFG_DATA_BITS-1:0] data);
    stim_row_t row;
    row = '{ROW_WRITE, idx, data, '0, '0, '0, '0, EXP_NONE, '0, '0, '0};
    directed_rows.insert(directed_rows.size(), row);
  endfunction

  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 15);
    if (no_gaps || roll < 8)
      return 0;
    if (roll < 14)
      return $urandom_range(1, 3);
    return $urandom_range(5, 30);
  endfunction

  // Sets random bits above the register width half of the time.
  function automatic logic [dpb_pkg::CFG_DATA_BITS-1:0] with_junk(
      input logic [dpb_pkg::CFG_DATA_BITS-1:0] value, input int bits);
    logic [dpb_pkg::CFG_DATA_BITS-1:0] keep;
    keep = (bits >= dpb_pkg::CFG_DATA_BITS) ? '1 : ((32'd1 << bits) - 32'd1);
    if ($urandom_range(0, 1) == 0)
      return value & keep;
    return (value & keep) | ($urandom & ~keep);
  endfunction

  function automatic logic [dpb_pkg::CFG_DATA_BITS-1:0] pick_size();
    case ($urandom_range(0, 7))
      0: return 32'd0;
      1: return 32'd1;
      2: return 32'd4095;
      3: return $urandom_range(1, 4095);
      default: return $urandom_range(1, 12);
    endcase
  endfunction

  function automatic logic [dpb_pkg::CFG_DATA_BITS-1:0] pick_center();
    case ($urandom_range(0, 5))
      0: return 32'd0;
      1: return 32'h1FFF;
      2: return $urandom_range(0, 8191);
      default: return $urandom_range(0, 40);
    endcase
  endfunction

  function automatic logic [dpb_pkg::CFG_DATA_BITS-1:0] pick_focal();
    case ($urandom_range(0, 7))
      0: return 32'd0;
      1: return 32'hFF_FFFF;
      2: return 32'd1;
      3: return 32'd32389;
      default: return ($urandom & 32'hFF_FFFF) >> $urandom_range(0, 16);
    endcase
  endfunction

  // Leaves cfg_write high; the caller lowers it after the last write.
  task automatic write_reg(input logic [dpb_pkg::CFG_INDEX_BITS-1:0] idx,
      input logic [dpb_pkg::CFG_DATA_BITS-1:0] data);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    case (idx)
      dpb_pkg::REG_IMAGE_WIDTH:     cam_width = data[dpb_pkg::SIZE_BITS-1:0];
      dpb_pkg::REG_IMAGE_HEIGHT:    cam_height = data[dpb_pkg::SIZE_BITS-1:0];
      dpb_pkg::REG_CENTER_X_HALF:   cam_cx_half = data[dpb_pkg::CENTER_BITS-1:0];
      dpb_pkg::REG_CENTER_Y_HALF:   cam_cy_half = data[dpb_pkg::CENTER_BITS-1:0];
      dpb_pkg::REG_INV_FOCAL_X:     cam_inv_fx = data[dpb_pkg::INV_FOCAL_BITS-1:0];
      dpb_pkg::REG_INV_FOCAL_Y:     cam_inv_fy = data[dpb_pkg::INV_FOCAL_BITS-1:0];
      dpb_pkg::REG_INV_DEPTH_SCALE: cam_inv_scale = data[dpb_pkg::INV_SCALE_BITS-1:0];
      default: ;
    endcase
  endtask

  // Returns at the edge that takes the beat, with in_valid still high.
  task automatic send_pixel(input logic [dpb_pkg::DEPTH_BITS-1:0] d,
      input logic [dpb_pkg::COLOR_BITS-1:0] b, input logic [dpb_pkg::COLOR_BITS-1:0] g,
      input logic [dpb_pkg::COLOR_BITS-1:0] r, input exp_kind_t how,
      input logic [dpb_pkg::POINT_BITS-1:0] x, input logic [dpb_pkg::POINT_BITS-1:0] y,
      input logic [dpb_pkg::POINT_BITS-1:0] z);
    int gap;
    gap = pick_gap();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    depth_raw <= d;
    blue <= b;
    green <= g;
    red <= r;
    beat_check <= how;
    beat_x <= x;
    beat_y <= y;
    beat_z <= z;
    do @(posedge clk); while (!in_ready);
  endtask

  // Zero-depth pixels leave no beat behind, so wait out the pipeline as well.
  // The first edge lets the monitor record the last accepted beat.
  task automatic settle(input int cycles);
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_points.size() != 0) @(posedge clk);
    repeat (cycles) @(posedge clk);
  endtask

  task automatic reconfigure(input bit all_regs);
    logic [dpb_pkg::CFG_DATA_BITS-1:0] scale;
    if (all_regs || $urandom_range(0, 9) < 7)
      write_reg(dpb_pkg::REG_IMAGE_WIDTH, with_junk(pick_size(), dpb_pkg::SIZE_BITS));
    if (all_regs || $urandom_range(0, 9) < 7)
      write_reg(dpb_pkg::REG_IMAGE_HEIGHT, with_junk(pick_size(), dpb_pkg::SIZE_BITS));
    if (all_regs || $urandom_range(0, 9) < 7)
      write_reg(dpb_pkg::REG_CENTER_X_HALF,
                with_junk(pick_center(), dpb_pkg::CENTER_BITS));
    if (all_regs || $urandom_range(0, 9) < 7)
      write_reg(dpb_pkg::REG_CENTER_Y_HALF,
                with_junk(pick_center(), dpb_pkg::CENTER_BITS));
    if (all_regs || $urandom_range(0, 9) < 7)
      write_reg(dpb_pkg::REG_INV_FOCAL_X,
                with_junk(pick_focal(), dpb_pkg::INV_FOCAL_BITS));
    if (all_regs || $urandom_range(0, 9) < 7)
      write_reg(dpb_pkg::REG_INV_FOCAL_Y,
                with_junk(pick_focal(), dpb_pkg::INV_FOCAL_BITS));
    if (all_regs || $urandom_range(0, 9) < 7) begin
      case ($urandom_range(0, 7))
        0: scale = 32'd0;
        1: scale = 32'hFFFF_FFFF;
        2: scale = 32'd4294967;
        3: scale = 32'h0001_0000;
        default: scale = $urandom >> $urandom_range(0, 20);
      endcase
      write_reg(dpb_pkg::REG_INV_DEPTH_SCALE, scale);
    end
    if ($urandom_range(0, 9) == 0)
      write_reg(REG_UNMAPPED, $urandom);
    cfg_write <= 1'b0;
  endtask

  // Predict at each accepted pixel beat, then step the raster position.
  always @(posedge clk) begin : watch_pixels
    cloud_point_t guess;
    logic [COORD_W-1:0] next_col;
    logic [COORD_W-1:0] next_row;
    if (!rst && in_valid && in_ready) begin
      guess = backproject(depth_raw, blue, green, red);
      if (beat_check == EXP_POINT)
        guess = '{beat_x, beat_y, beat_z, blue, green, red};
      if (beat_check == EXP_POINT || (beat_check == EXP_PREDICTED && depth_raw != '0))
        pending_points.insert(pending_points.size(), guess);
      next_col = col_pos + 1'b1;
      next_row = row_pos;
      if (next_col >= cam_width) begin
        next_col = '0;
        next_row = row_pos + 1'b1;
        if (next_row >= cam_height)
          next_row = '0;
      end
      col_pos = next_col;
      row_pos = next_row;
    end
  end

  always @(posedge clk) begin : check_points
    cloud_point_t seen;
    cloud_point_t want;
    if (!rst && out_valid && out_ready) begin
      seen = '{point_x, point_y, point_z, out_blue, out_green, out_red};
      if (pending_points.size() == 0) begin
        if (mismatches < REPORT_LIMIT)
          $display("unexpected point beat: x=%h y=%h z=%h bgr=%h %h %h",
                   seen.x, seen.y, seen.z, seen.b, seen.g, seen.r);
        mismatches++;
      end else begin
        want = pending_points.pop_front();
        if (seen !== want) begin
          if (mismatches < REPORT_LIMIT) begin
            $display("point mismatch: expected x=%h y=%h z=%h bgr=%h %h %h",
                     want.x, want.y, want.z, want.b, want.g, want.r);
            $display("                actual   x=%h y=%h z=%h bgr=%h %h %h",
                     seen.x, seen.y, seen.z, seen.b, seen.g, seen.r);
          end
          mismatches++;
        end
      end
    end
  end

  // Output back-pressure: steady stretches alternate with random stalls.
  always @(posedge clk) begin : drive_sink
    int pick;
    if (mode_left == 0) begin
      sink_steady = ($urandom_range(0, 2) == 0);
      mode_left = $urandom_range(50, 400);
    end else begin
      mode_left--;
    end
    if (stall_left != 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else if (sink_steady) begin
      out_ready <= 1'b1;
    end else begin
      pick = $urandom_range(0, 15);
      if (pick < 9) begin
        out_ready <= 1'b1;
      end else begin
        out_ready <= 1'b0;
        stall_left = (pick < 14) ? $urandom_range(0, 3) : $urandom_range(5, 40);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || cfg_write || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == STALL_LIMIT) begin
      $display("depth_pixel_backprojection regression: fail");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int remaining;
    int burst;
    bit writing;
    bit first;
    logic [dpb_pkg::DEPTH_BITS-1:0] d;

    // Reset camera settings, starting at the top-left pixel.
    add_pixel(16'h0000, 8'h00, 8'h00, 8'h00, EXP_NONE, '0, '0, '0);
    add_pixel(16'h0001, 8'hFF, 8'h00, 8'hA5, EXP_PREDICTED, '0, '0, '0);
    add_pixel(16'hFFFF, 8'h00, 8'hFF, 8'h5A, EXP_PREDICTED, '0, '0, '0);
    add_pixel(16'h8000, 8'h81, 8'h7E, 8'hFF, EXP_PREDICTED, '0, '0, '0);
    add_pixel(16'h7FFF, 8'h3C, 8'hC3, 8'h00, EXP_PREDICTED, '0, '0, '0);
    // A 2x2 image at the largest gains: x pins low, y pins high on row one.
    add_write(dpb_pkg::REG_IMAGE_WIDTH, 32'd2);
    add_write(dpb_pkg::REG_IMAGE_HEIGHT, 32'd2);
    add_write(dpb_pkg::REG_CENTER_X_HALF, 32'd8190);
    add_write(dpb_pkg::REG_CENTER_Y_HALF, 32'd0);
    add_write(dpb_pkg::REG_INV_FOCAL_X, 32'hFF_FFFF);
    add_write(dpb_pkg::REG_INV_FOCAL_Y, 32'hFF_FFFF);
    add_write(dpb_pkg::REG_INV_DEPTH_SCALE, 32'hFFFF_FFFF);
    // The column is already past the new width, so it wraps after this pixel.
    add_pixel(16'hFFFF, 8'h11, 8'h22, 8'h33, EXP_POINT, POINT_MIN, '0, Z_FULL);
    add_pixel(16'hFFFF, 8'h44, 8'h55, 8'h66, EXP_POINT, POINT_MIN, POINT_MAX, Z_FULL);
    add_pixel(16'h0000, 8'h77, 8'h88, 8'h99, EXP_NONE, '0, '0, '0);
    add_pixel(16'hFFFF, 8'hAA, 8'hBB, 8'hCC, EXP_POINT, POINT_MIN, '0, Z_FULL);
    add_pixel(16'hFFFF, 8'hDD, 8'hEE, 8'hFF, EXP_POINT, POINT_MIN, '0, Z_FULL);
    // A zero depth scale flattens every point; the unmapped index changes nothing.
    add_write(dpb_pkg::REG_INV_DEPTH_SCALE, 32'd0);
    add_write(REG_UNMAPPED, 32'hFFFF_FFFF);
    add_pixel(16'hFFFF, 8'h01, 8'h02, 8'h04, EXP_POINT, '0, '0, '0);
    add_pixel(16'h0001, 8'h08, 8'h10, 8'h20, EXP_POINT, '0, '0, '0);
    // Zero width and height pin the position at the principal point.
    add_write(dpb_pkg::REG_IMAGE_WIDTH, 32'd0);
    add_write(dpb_pkg::REG_IMAGE_HEIGHT, 32'd0);
    add_write(dpb_pkg::REG_CENTER_X_HALF, 32'd0);
    add_write(dpb_pkg::REG_CENTER_Y_HALF, 32'd0);
    add_write(dpb_pkg::REG_INV_DEPTH_SCALE, 32'h0001_0000);
    add_pixel(16'h1234, 8'h40, 8'h80, 8'hFE, EXP_POINT, '0, '0, 32'h0000_1234);
    add_pixel(16'hFFFF, 8'hFD, 8'hFB, 8'hF7, EXP_POINT, '0, '0, 32'h0000_FFFF);
    add_pixel(16'h0000, 8'hEF, 8'hDF, 8'hBF, EXP_NONE, '0, '0, '0);
    // Junk above the register widths must be dropped.
    add_write(dpb_pkg::REG_IMAGE_WIDTH, 32'd3);
    add_write(dpb_pkg::REG_IMAGE_HEIGHT, 32'hFFFF_F002);
    add_write(dpb_pkg::REG_CENTER_X_HALF, 32'hFFFF_E003);
    add_write(dpb_pkg::REG_CENTER_Y_HALF, 32'd5);
    add_write(dpb_pkg::REG_INV_FOCAL_X, 32'hFF80_0000);
    add_write(dpb_pkg::REG_INV_FOCAL_Y, 32'h0100_0001);
    add_pixel(16'h0001, 8'h12, 8'h34, 8'h56, EXP_PREDICTED, '0, '0, '0);
    add_pixel(16'h0002, 8'h78, 8'h9A, 8'hBC, EXP_PREDICTED, '0, '0, '0);
    add_pixel(16'h0003, 8'hDE, 8'hF0, 8'h0F, EXP_PREDICTED, '0, '0, '0);
    add_pixel(16'h00FF, 8'hED, 8'hCB, 8'hA9, EXP_PREDICTED, '0, '0, '0);
    add_pixel(16'h4000, 8'h87, 8'h65, 8'h43, EXP_PREDICTED, '0, '0, '0);
    add_pixel(16'hFFFE, 8'h21, 8'h0E, 8'hE0, EXP_PREDICTED, '0, '0, '0);

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    writing = 1'b0;
    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_WRITE) begin
        if (!writing)
          settle(SETTLE_CYCLES);
        write_reg(directed_rows[i].index, directed_rows[i].data);
        writing = 1'b1;
      end else begin
        if (writing)
          cfg_write <= 1'b0;
        writing = 1'b0;
        send_pixel(directed_rows[i].depth, directed_rows[i].b, directed_rows[i].g,
                   directed_rows[i].r, directed_rows[i].how, directed_rows[i].x,
                   directed_rows[i].y, directed_rows[i].z);
      end
    end

    // Random frames, each under fresh camera settings. The position is kept
    // across a change, so some phases start beyond the new image size.
    remaining = RANDOM_PIXELS;
    first = 1'b1;
    while (remaining > 0) begin
      settle(SETTLE_CYCLES);
      reconfigure(first);
      first = 1'b0;
      no_gaps = ($urandom_range(0, 3) == 0);
      burst = $urandom_range(40, 200);
      if (burst > remaining)
        burst = remaining;
      repeat (burst) begin
        case ($urandom_range(0, 15))
          0, 1: d = '0;
          2: d = 16'hFFFF;
          3: d = 16'h0001;
          4, 5: d = $urandom_range(1, 4096);
          default: d = $urandom;
        endcase
        send_pixel(d, 8'($urandom), 8'($urandom), 8'($urandom), EXP_PREDICTED, '0, '0, '0);
      end
      remaining -= burst;
    end

    settle(DRAIN_CYCLES);
    if (mismatches == 0 && pending_points.size() == 0)
      $display("depth_pixel_backprojection regression: pass");
    else
      $display("depth_pixel_backprojection regression: fail");
    $finish;
  end

endmodule

### files.f
design/dpb_pkg.sv
design/dpb_front.sv
design/dpb_queue.sv
design/dpb_back.sv
design/depth_pixel_backprojection.sv
test/depth_pixel_backprojection_tb.sv
